FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL files.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Condition that must never be seen out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");

`endif

FILE: hdl/itoa_pkg.sv
// Shared types, constants and helpers for the integer-to-ASCII converter.
// No dependencies.
`timescale 1ns / 1ps

package itoa_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int MAG_WIDTH      = 32;
    localparam int STEP_BITS      = 4;

    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;
    localparam logic [5:0] RADIX_DEC = 6'd10;

    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_A     = 7'h61;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;
    localparam logic [6:0] CHAR_NONE  = 7'h00;

    typedef struct packed {
        logic                 err;
        logic                 neg;
        logic [5:0]           radix;
        logic [MAG_WIDTH-1:0] mag;
    } t_item;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } t_bk_state;

    // digit value 0..35 to its ASCII character
    function automatic logic [6:0] digit_char(input logic [5:0] d);
        logic [6:0] d7;
        d7 = {1'b0, d};
        if (d < RADIX_DEC) begin
            return 7'(CHAR_ZERO + d7);
        end else begin
            return 7'(CHAR_A + d7 - {1'b0, RADIX_DEC});
        end
    endfunction

endpackage

FILE: hdl/itoa_front.sv
// Front end: takes words, checks the radix, folds the sign, queues the job.
// Depends on itoa_pkg and assert_macros.svh.
`timescale 1ns / 1ps

module itoa_front #(
    parameter int DATA_WIDTH = itoa_pkg::DATA_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [31:0]          i_value,
    input  logic [5:0]           i_base,
    input  logic                 i_mode,
    output logic                 o_valid,
    output itoa_pkg::t_item      o_item,
    input  logic                 i_pop
);
    import itoa_pkg::*;
    `include "assert_macros.svh"

    localparam int DEPTH = 2;

    logic [DATA_WIDTH-1:0] c_v;
    logic                  c_neg;
    t_item                 c_item;
    logic                  c_push;

    t_item      r_mem [DEPTH];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    always_comb begin
        c_v          = i_value[DATA_WIDTH-1:0];
        c_neg        = !i_mode && (i_base == RADIX_DEC) && c_v[DATA_WIDTH-1];
        c_item.err   = (i_base < RADIX_MIN) || (i_base > RADIX_MAX);
        c_item.neg   = c_neg;
        c_item.radix = i_base;
        c_item.mag   = c_neg ? MAG_WIDTH'(DATA_WIDTH'(0) - c_v) : MAG_WIDTH'(c_v);
    end

    assign busy    = (r_count == 2'(DEPTH));
    assign c_push  = start && !busy;
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (c_push) begin
            r_mem[r_wptr] <= c_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (c_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= 2'(r_count + {1'b0, c_push} - {1'b0, i_pop});
        end
    end

    `ASSERT_NEVER(a_cnt_range, i_clk, i_rst_n, r_count > 2'(DEPTH))
    `ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && (r_count == 2'd0))
    `ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, c_push && !i_pop, r_count != 2'd0)

endmodule

FILE: hdl/itoa_back.sv
// Back end: radix division four bits a cycle, digit stack, character output.
// Depends on itoa_pkg and assert_macros.svh.
`timescale 1ns / 1ps

module itoa_back #(
    parameter int DATA_WIDTH = itoa_pkg::DATA_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  itoa_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_strobe,
    output logic [6:0]      o_char_out,
    output logic            o_last,
    output logic            o_error
);
    import itoa_pkg::*;
    `include "assert_macros.svh"

    localparam int NSTEP = (DATA_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int QW    = NSTEP * STEP_BITS;
    localparam int SW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
    localparam int IW    = $clog2(DATA_WIDTH);
    localparam int CW    = $clog2(DATA_WIDTH + 1);

    t_bk_state r_state, n_state;

    logic [QW-1:0]  r_quo, n_quo;
    logic [5:0]     r_rem, n_rem;
    logic [SW-1:0]  r_step;
    logic [CW-1:0]  r_ndig;
    logic [CW-1:0]  c_top;
    logic           r_neg;
    logic [5:0]     r_radix;
    logic [5:0]     r_stack [DATA_WIDTH];
    logic           r_strobe;
    logic [6:0]     r_char;
    logic           r_last;
    logic           r_err;

    logic c_pop, c_load, c_emit_err, c_div, c_emit, c_step_end;
    logic [STEP_BITS-1:0] c_qb;
    logic [6:0]           c_t;

    // restoring division, STEP_BITS quotient bits per cycle
    always_comb begin
        n_rem = r_rem;
        c_qb  = '0;
        c_t   = '0;
        for (int k = 0; k < STEP_BITS; k++) begin
            c_t = {n_rem, r_quo[QW-1-k]};
            if (c_t >= {1'b0, r_radix}) begin
                n_rem             = 6'(c_t - {1'b0, r_radix});
                c_qb[STEP_BITS-1-k] = 1'b1;
            end else begin
                n_rem = c_t[5:0];
            end
        end
        n_quo = {r_quo[QW-STEP_BITS-1:0], c_qb};
    end

    assign c_step_end = (r_step == SW'(NSTEP - 1));
    assign c_top      = CW'(r_ndig - CW'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_valid && !i_item.err) begin
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                if (c_step_end && (n_quo == '0)) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (!r_neg && (r_ndig == CW'(1))) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // control decodes
    always_comb begin
        c_pop      = 1'b0;
        c_load     = 1'b0;
        c_emit_err = 1'b0;
        c_div      = 1'b0;
        c_emit     = 1'b0;
        case (r_state)
            BK_IDLE: begin
                c_pop      = i_valid;
                c_load     = i_valid && !i_item.err;
                c_emit_err = i_valid && i_item.err;
            end
            BK_DIV:  c_div  = 1'b1;
            BK_EMIT: c_emit = 1'b1;
            default: c_pop  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_strobe <= 1'b0;
            r_ndig   <= '0;
            r_step   <= '0;
            r_neg    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= c_emit_err || c_emit;
            if (c_load) begin
                r_quo   <= QW'(i_item.mag[DATA_WIDTH-1:0]);
                r_rem   <= '0;
                r_step  <= '0;
                r_ndig  <= '0;
                r_neg   <= i_item.neg;
                r_radix <= i_item.radix;
            end
            if (c_div) begin
                if (c_step_end) begin
                    r_stack[r_ndig[IW-1:0]] <= n_rem;
                    r_ndig <= CW'(r_ndig + CW'(1));
                    r_rem  <= '0;
                    r_step <= '0;
                end else begin
                    r_rem  <= n_rem;
                    r_step <= SW'(r_step + SW'(1));
                end
                r_quo <= n_quo;
            end
            if (c_emit) begin
                if (r_neg) begin
                    r_neg <= 1'b0;
                end else begin
                    r_ndig <= c_top;
                end
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (c_emit_err) begin
            r_char <= CHAR_NONE;
            r_last <= 1'b1;
            r_err  <= 1'b1;
        end else if (c_emit) begin
            r_err <= 1'b0;
            if (r_neg) begin
                r_char <= CHAR_MINUS;
                r_last <= 1'b0;
            end else begin
                r_char <= digit_char(r_stack[c_top[IW-1:0]]);
                r_last <= (r_ndig == CW'(1));
            end
        end
    end

    assign o_pop      = c_pop;
    assign o_strobe   = r_strobe;
    assign o_char_out = r_char;
    assign o_last     = r_last;
    assign o_error    = r_err;

    `ASSERT_IMPLIES(a_err_last, i_clk, i_rst_n, r_strobe && r_err, r_last)
    `ASSERT_IMPLIES(a_sign_not_last, i_clk, i_rst_n, r_strobe && (r_char == CHAR_MINUS), !r_last)
    `ASSERT_NEVER(a_ndig_range, i_clk, i_rst_n, r_ndig > CW'(DATA_WIDTH))

endmodule

FILE: hdl/integer_to_ascii_radix_top.sv
// Integer to ASCII text, radix 2 to 36: once a word is divided, its characters come out one
// character a cycle. The back end takes a word only while idle, divides it to the digit stack,
// then emits them; the front queue takes new words meanwhile. The radix divider sets the rate.
// Synchronous active-low reset empties the queue and idles the divider; results cannot stall.
// Depends on itoa_pkg, itoa_front, itoa_back.
`timescale 1ns / 1ps

module integer_to_ascii_radix_top #(
    parameter int DATA_WIDTH = itoa_pkg::DATA_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_value,
    input  logic [5:0]  i_base,
    input  logic        i_mode,
    output logic        o_strobe,
    output logic [6:0]  o_char_out,
    output logic        o_last,
    output logic        o_error
);
    import itoa_pkg::*;

    // front -> back job handoff through a two-word queue
    logic  w_valid;
    t_item w_item;
    logic  w_pop;

    // Front: radix check, sign fold for signed decimal, queue.
    itoa_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_value (i_value),
        .i_base  (i_base),
        .i_mode  (i_mode),
        .o_valid (w_valid),
        .o_item  (w_item),
        .i_pop   (w_pop)
    );

    // Back: repeated division by the radix, digits stacked LSD first,
    // then read out MSD first with an optional leading minus.
    itoa_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid),
        .i_item     (w_item),
        .o_pop      (w_pop),
        .o_strobe   (o_strobe),
        .o_char_out (o_char_out),
        .o_last     (o_last),
        .o_error    (o_error)
    );

endmodule

FILE: test/integer_to_ascii_radix_top_tb.sv
// Self-checking bench for integer_to_ascii_radix_top: directed corner words, then random
// words under three sender idle profiles, each character checked against a local predictor.
// Depends on itoa_pkg and integer_to_ascii_radix_top.
`timescale 1ns / 1ps

module integer_to_ascii_radix_top_tb;
    import itoa_pkg::*;

    // Longest quiet stretch: a base-2 word of 32 digits spends the longest time in division
    // before its first character, plus the handoff and a sender gap.
    localparam int QUIET_LIMIT = 4000;
    localparam int WORDS_PER_PHASE = 115;
    localparam int TAIL_CYCLES = 40;

    // One expected character of the text stream.
    typedef struct packed {
        logic [6:0] ch;
        logic       last;
        logic       err;
    } t_char_rec;

    // Holds the expected characters of every accepted word, oldest first, and
    // compares each strobed character against the head of the queue.
    class itoa_scoreboard;
        t_char_rec expected_chars[$];
        int        mismatch_cnt;
        int        chars_checked;

        function new();
            mismatch_cnt  = 0;
            chars_checked = 0;
        endfunction

        // Predict the text of one accepted word and queue its characters.
        function void note_word(logic [31:0] value, logic [5:0] base, logic mode);
            logic [31:0] mag;
            logic [5:0]  d;
            logic        neg;
            logic [6:0]  digits[$];
            t_char_rec   rec;
            if (base < RADIX_MIN || base > RADIX_MAX) begin
                rec = '{ch: CHAR_NONE, last: 1'b1, err: 1'b1};
                expected_chars.push_back(rec);
                return;
            end
            // only signed decimal gets a sign; the most negative value wraps to
            // its own unsigned magnitude, which is what we want
            neg = !mode && base == RADIX_DEC && value[31];
            mag = neg ? 32'(-value) : value;
            do begin
                d   = 6'(mag % {26'd0, base});
                mag = mag / {26'd0, base};
                if (d < RADIX_DEC) digits.push_front(7'(CHAR_ZERO + {1'b0, d}));
                else digits.push_front(7'(CHAR_A + {1'b0, d} - {1'b0, RADIX_DEC}));
            end while (mag != 0);
            if (neg) begin
                rec = '{ch: CHAR_MINUS, last: 1'b0, err: 1'b0};
                expected_chars.push_back(rec);
            end
            foreach (digits[i]) begin
                rec = '{ch: digits[i], last: (i == digits.size() - 1), err: 1'b0};
                expected_chars.push_back(rec);
            end
        endfunction

        function void check_char(logic [6:0] ch, logic last, logic err);
            t_char_rec want;
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character: char=%h last=%b error=%b",
                         $time, ch, last, err);
                mismatch_cnt++;
                return;
            end
            want = expected_chars.pop_front();
            chars_checked++;
            if (ch !== want.ch) begin
                $display("%0t: char_out mismatch: expected %h actual %h", $time, want.ch, ch);
                mismatch_cnt++;
            end
            if (last !== want.last) begin
                $display("%0t: last mismatch: expected %b actual %b", $time, want.last, last);
                mismatch_cnt++;
            end
            if (err !== want.err) begin
                $display("%0t: error mismatch: expected %b actual %b", $time, want.err, err);
                mismatch_cnt++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_value;
    logic [5:0]  i_base;
    logic        i_mode;
    logic        o_strobe;
    logic [6:0]  o_char_out;
    logic        o_last;
    logic        o_error;

    itoa_scoreboard sb = new();

    int words_in    = 0;
    int bad_radix   = 0;   // words with a radix outside 2..36
    int neg_decimal = 0;   // signed decimal words that take a minus sign
    int quiet_cycles = 0;

    integer_to_ascii_radix_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_value    (i_value),
        .i_base     (i_base),
        .i_mode     (i_mode),
        .o_strobe   (o_strobe),
        .o_char_out (o_char_out),
        .o_last     (o_last),
        .o_error    (o_error)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Monitor: everything is sampled at the rising edge, before the DUT's
    // registers update. A word is taken when start is high and busy low.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                sb.note_word(i_value, i_base, i_mode);
                words_in <= words_in + 1;
                if (i_base < RADIX_MIN || i_base > RADIX_MAX) bad_radix <= bad_radix + 1;
                else if (!i_mode && i_base == RADIX_DEC && i_value[31])
                    neg_decimal <= neg_decimal + 1;
            end
            if (o_strobe) sb.check_char(o_char_out, o_last, o_error);
        end
        // watchdog sees only cycles where neither side moved a word
        if (i_rst_n && ((start && !busy) || o_strobe)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no progress for %0d cycles, %0d characters still due",
                 $time, QUIET_LIMIT, sb.pending());
        $display("integer_to_ascii_radix_top_tb NOT OK");
        $finish;
    end

    // Present one word at a falling edge and hold it until the monitor has
    // seen it taken. Returns on a falling edge.
    task automatic send_word(input logic [31:0] v, input logic [5:0] b, input logic m);
        int seen;
        seen = words_in;
        i_value <= v;
        i_base  <= b;
        i_mode  <= m;
        start   <= 1'b1;
        do @(negedge i_clk); while (words_in == seen);
    endtask

    // Optionally drop start for a random gap; start is touched once per edge.
    task automatic sender_gap(input int pct);
        if ($urandom_range(99) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    function automatic logic [5:0] pick_base();
        int r;
        r = $urandom_range(99);
        if (r < 4) return 6'($urandom_range(0, 1));
        if (r < 9) return 6'($urandom_range(37, 63));
        if (r < 35) return RADIX_DEC;
        if (r < 45) return (r < 40) ? 6'd16 : 6'd2;
        return 6'($urandom_range(2, 36));
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 32'($urandom_range(0, 100));
        if (r < 22) begin
            case ($urandom_range(3))
                0: return 32'h0000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h8000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (r < 35) return 32'(-$urandom_range(1, 1000));
        return $urandom();
    endfunction

    task automatic random_phase(input int pct);
        repeat (WORDS_PER_PHASE) begin
            send_word(pick_value(), pick_base(), 1'($urandom_range(1)));
            sender_gap(pct);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_value = '0;
        i_base  = '0;
        i_mode  = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed words, back to back.
        send_word(32'd0,          RADIX_DEC, 1'b0);  // zero gives "0"
        send_word(32'd1,          RADIX_DEC, 1'b0);
        send_word(32'hFFFF_FFFF,  RADIX_DEC, 1'b0);  // -1
        send_word(32'h8000_0000,  RADIX_DEC, 1'b0);  // most negative, magnitude wraps
        send_word(32'h7FFF_FFFF,  RADIX_DEC, 1'b0);
        send_word(32'd12345,      RADIX_DEC, 1'b0);
        send_word(-32'd907,       RADIX_DEC, 1'b0);
        send_word(32'hFFFF_FFFF,  RADIX_DEC, 1'b1);  // unsigned, no sign
        send_word(32'hFFFF_FFFF,  RADIX_MIN, 1'b1);  // longest text, 32 digits
        send_word(32'h8000_0000,  RADIX_MIN, 1'b0);  // negative but not decimal
        send_word(32'd0,          RADIX_MIN, 1'b1);
        send_word(32'hFFFF_FFFF,  RADIX_MAX, 1'b0);
        send_word(32'd35,         RADIX_MAX, 1'b1);  // single 'z'
        send_word(32'd34,         6'd35,     1'b0);  // single 'y'
        send_word(32'h8000_0000,  6'd16,     1'b0);
        send_word(32'hDEAD_BEEF,  6'd16,     1'b1);
        send_word(32'hFFFF_FFFF,  6'd8,      1'b0);
        send_word(32'hFFFF_FFFF,  6'd3,      1'b1);
        send_word(32'd10,         6'd11,     1'b1);  // 'a'
        send_word(32'h1234_5678,  6'd0,      1'b0);  // radix errors
        send_word(32'h1234_5678,  6'd1,      1'b1);
        send_word(32'hFFFF_FFFF,  6'd37,     1'b0);
        send_word(32'd0,          6'd63,     1'b1);

        random_phase(29);
        random_phase(85);
        random_phase(0);

        start <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Sent %0d words (%0d bad radix, %0d negative decimal), checked %0d characters",
                 words_in, bad_radix, neg_decimal, sb.chars_checked);
        $display("Mismatches: %0d", sb.mismatch_cnt);
        if (sb.mismatch_cnt == 0 && sb.pending() == 0) begin
            $display("integer_to_ascii_radix_top_tb OK");
        end else begin
            $display("integer_to_ascii_radix_top_tb NOT OK");
        end
        $finish;
    end

endmodule
